[src/msp_pkg.sv]
// Shared types, byte codes and the CRC-8/DVB-S2 step for the MSP v1/v2 deframer.
// No dependencies; msp_v1_v2_frame_parser_core and msp_check import this package.
package msp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h24;  // '$'
    localparam logic [7:0] MARK_V1     = 8'h4D;  // 'M'
    localparam logic [7:0] MARK_V2     = 8'h58;  // 'X'
    localparam logic [7:0] DIR_REQ_CH  = 8'h3C;  // '<'
    localparam logic [7:0] DIR_RPL_CH  = 8'h3E;  // '>'
    localparam logic [7:0] DIR_ERR_CH  = 8'h21;  // '!'
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_REPORT  = 1'b1;
    localparam logic       VER_V1       = 1'b0;
    localparam logic       VER_V2       = 1'b1;
    localparam logic [1:0] DIR_REQUEST  = 2'd0;
    localparam logic [1:0] DIR_REPLY    = 2'd1;
    localparam logic [1:0] DIR_ERROR    = 2'd2;
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHECK = 2'd1;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

    typedef enum logic [11:0] {
        ST_HUNT   = 12'b0000_0000_0001,
        ST_MARK   = 12'b0000_0000_0010,
        ST_DIR    = 12'b0000_0000_0100,
        ST_V1LEN  = 12'b0000_0000_1000,
        ST_V1CMD  = 12'b0000_0001_0000,
        ST_V2FLAG = 12'b0000_0010_0000,
        ST_V2CMDL = 12'b0000_0100_0000,
        ST_V2CMDH = 12'b0000_1000_0000,
        ST_V2LENL = 12'b0001_0000_0000,
        ST_V2LENH = 12'b0010_0000_0000,
        ST_DATA   = 12'b0100_0000_0000,
        ST_CHECK  = 12'b1000_0000_0000
    } t_phase;

    // One CRC-8/DVB-S2 byte update, MSB first.
    function automatic logic [7:0] crc8_dvb_s2(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/msp_stream_if.sv]
// Valid/ready channels of the MSP deframer: received bytes in, result beats out.
// Depends on nothing but the port widths fixed by the frame format.
interface msp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic        frame_version;
    logic [1:0]  frame_direction;
    logic [15:0] frame_command;
    logic [15:0] payload_length;
    logic [1:0]  frame_status;

    modport source (output valid, output item_kind, output data_byte, output frame_version,
                    output frame_direction, output frame_command, output payload_length,
                    output frame_status, input ready);
    modport sink   (input valid, input item_kind, input data_byte, input frame_version,
                    input frame_direction, input frame_command, input payload_length,
                    input frame_status, output ready);
endinterface

[src/msp_v1_v2_frame_parser_core.sv]
// MSP v1/v2 deframer top level: byte input register, header/payload parser, result register.
// Depends on msp_pkg, msp_stream_if.sv and msp_check.
//
// Path: an accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless o_res stalls; result and input register advance together,
// so a byte is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low): parser back to hunting for '$', header state and check
// cleared, max_payload set to 255, both registers emptied.
module msp_v1_v2_frame_parser_core
    import msp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    msp_rx_if.sink      i_rx,
    msp_res_if.source   o_res
);

    logic [15:0] r_max_payload;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase,   n_phase;
    logic        r_version, n_version;
    logic [1:0]  r_dir,     n_dir;
    logic [15:0] r_command, n_command;
    logic [15:0] r_length,  n_length;
    logic [15:0] r_count,   n_count;
    logic [7:0]  r_check,   n_check;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_data;
    logic        r_out_version;
    logic [1:0]  r_out_dir;
    logic [15:0] r_out_command;
    logic [15:0] r_out_length;
    logic [1:0]  r_out_status;

    logic        out_free;
    logic        proc;
    logic        emit;
    logic        n_kind;
    logic [7:0]  n_data;
    logic [1:0]  n_status;
    logic [7:0]  folded;
    logic [15:0] count_inc;

    assign out_free  = !r_out_valid || o_res.ready;
    assign proc      = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;
    assign count_inc = r_count + 16'd1;

    msp_check u_check (
        .i_version (r_version),
        .i_check   (r_check),
        .i_byte    (r_in_byte),
        .o_check   (folded)
    );

    always_comb begin
        n_phase   = r_phase;
        n_version = r_version;
        n_dir     = r_dir;
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        n_check   = r_check;
        emit      = 1'b0;
        n_kind    = KIND_PAYLOAD;
        n_data    = 8'd0;
        n_status  = STATUS_OK;
        unique case (r_phase)
            ST_MARK: begin
                if (r_in_byte == MARK_V1) begin
                    n_version = VER_V1;
                    n_phase   = ST_DIR;
                end else if (r_in_byte == MARK_V2) begin
                    n_version = VER_V2;
                    n_phase   = ST_DIR;
                end else begin
                    // rescan the same byte for a fresh sync
                    n_phase = (r_in_byte == SYNC_BYTE) ? ST_MARK : ST_HUNT;
                end
            end
            ST_DIR: begin
                if (r_in_byte == DIR_REQ_CH || r_in_byte == DIR_RPL_CH ||
                    r_in_byte == DIR_ERR_CH) begin
                    n_dir   = (r_in_byte == DIR_REQ_CH) ? DIR_REQUEST :
                              (r_in_byte == DIR_RPL_CH) ? DIR_REPLY : DIR_ERROR;
                    n_check = 8'd0;
                    n_phase = (r_version == VER_V2) ? ST_V2FLAG : ST_V1LEN;
                end else begin
                    n_phase = (r_in_byte == SYNC_BYTE) ? ST_MARK : ST_HUNT;
                end
            end
            ST_V1LEN: begin
                n_check  = folded;
                n_length = {8'd0, r_in_byte};
                n_phase  = ST_V1CMD;
            end
            ST_V1CMD: begin
                n_check   = folded;
                n_command = {8'd0, r_in_byte};
                n_count   = 16'd0;
                n_phase   = (r_length != 16'd0) ? ST_DATA : ST_CHECK;
            end
            ST_V2FLAG: begin
                n_check = folded;
                n_phase = ST_V2CMDL;
            end
            ST_V2CMDL: begin
                n_check   = folded;
                n_command = {8'd0, r_in_byte};
                n_phase   = ST_V2CMDH;
            end
            ST_V2CMDH: begin
                n_check   = folded;
                n_command = {r_in_byte, r_command[7:0]};
                n_phase   = ST_V2LENL;
            end
            ST_V2LENL: begin
                n_check  = folded;
                n_length = {8'd0, r_in_byte};
                n_phase  = ST_V2LENH;
            end
            ST_V2LENH: begin
                n_check  = folded;
                n_length = {r_in_byte, r_length[7:0]};
                n_count  = 16'd0;
                n_phase  = ({r_in_byte, r_length[7:0]} != 16'd0) ? ST_DATA : ST_CHECK;
            end
            ST_DATA: begin
                // bytes past capacity are still folded into the check but dropped
                emit    = (r_count < r_max_payload);
                n_check = folded;
                n_count = count_inc;
                n_data  = r_in_byte;
                if (count_inc >= r_length) begin
                    n_phase = ST_CHECK;
                end
            end
            ST_CHECK: begin
                emit   = 1'b1;
                n_kind = KIND_REPORT;
                if (r_in_byte != r_check) begin
                    n_status = STATUS_BAD_CHECK;
                end else if (r_length > r_max_payload) begin
                    n_status = STATUS_TOO_LARGE;
                end else begin
                    n_status = STATUS_OK;
                end
                n_phase = ST_HUNT;
            end
            default: begin
                n_phase = (r_in_byte == SYNC_BYTE) ? ST_MARK : ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_HUNT;
            r_version <= VER_V1;
            r_dir     <= DIR_REQUEST;
            r_command <= 16'd0;
            r_length  <= 16'd0;
            r_count   <= 16'd0;
            r_check   <= 8'd0;
        end else if (proc) begin
            r_phase   <= n_phase;
            r_version <= n_version;
            r_dir     <= n_dir;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
            r_check   <= n_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_kind    <= n_kind;
            r_out_data    <= n_data;
            r_out_version <= r_version;
            r_out_dir     <= r_dir;
            r_out_command <= r_command;
            r_out_length  <= r_length;
            r_out_status  <= n_status;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.item_kind       = r_out_kind;
    assign o_res.data_byte       = r_out_data;
    assign o_res.frame_version   = r_out_version;
    assign o_res.frame_direction = r_out_dir;
    assign o_res.frame_command   = r_out_command;
    assign o_res.payload_length  = r_out_length;
    assign o_res.frame_status    = r_out_status;

    a_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ST_DATA) |-> (r_count < r_length))
        else $error("payload count reached length while still in data phase");

    a_report_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_REPORT) |-> (r_out_data == 8'd0))
        else $error("frame end report carries a data byte");

    a_payload_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_PAYLOAD) |-> (r_out_status == STATUS_OK))
        else $error("payload beat carries a non-ok status");

    a_input_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a byte while the result side stalled");

    a_direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dir != 2'd3))
        else $error("result beat carries an undefined direction code");

endmodule

[src/msp_check.sv]
// Running frame check: XOR for v1 frames, CRC-8/DVB-S2 for v2 frames.
// Depends on msp_pkg for the CRC step and version codes.
module msp_check
    import msp_pkg::*;
(
    input  logic       i_version,
    input  logic [7:0] i_check,
    input  logic [7:0] i_byte,
    output logic [7:0] o_check
);

    always_comb begin
        if (i_version == VER_V2) begin
            o_check = crc8_dvb_s2(i_check, i_byte);
        end else begin
            o_check = i_check ^ i_byte;
        end
    end

endmodule
